FILE: hdl/disk_controller_channel_sequencer_assert.svh
// Assertion macros shared by the disk controller channel sequencer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef DISK_CONTROLLER_CHANNEL_SEQUENCER_ASSERT_SVH
`define DISK_CONTROLLER_CHANNEL_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DCCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dccs_pkg.sv
// Shared types, function codes and constants of the disk channel sequencer.
// Used by dccs_core and the top level; depends on nothing else.
`timescale 1ns / 1ps
package dccs_pkg;

  localparam int NU = 8;  // storage slots: unit numbers are three bits wide

  // Default geometry and sizes of the attached drives.
  localparam int UNITS_DEF          = 8;
  localparam int CYLINDERS_DEF      = 843;
  localparam int TRACKS_DEF         = 10;
  localparam int SECTORS_DEF        = 32;
  localparam int SECTOR_WORDS_DEF   = 256;
  localparam int AUTOLOAD_WORDS_DEF = 16870;

  localparam logic [1:0] MODE_FUNC = 2'd0;
  localparam logic [1:0] MODE_OUT  = 2'd1;
  localparam logic [1:0] MODE_IN   = 2'd2;
  localparam logic [1:0] MODE_DISC = 2'd3;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_DECL = 2'd1;
  localparam logic [1:0] REPLY_ACPT = 2'd2;
  localparam logic [1:0] REPLY_PROC = 2'd3;

  localparam logic [11:0] F_SEEK   = 12'o0001;
  localparam logic [11:0] F_READ   = 12'o0004;
  localparam logic [11:0] F_WRITE  = 12'o0005;
  localparam logic [11:0] F_OPCOMP = 12'o0010;
  localparam logic [11:0] F_GSTAT  = 12'o0012;
  localparam logic [11:0] F_CONT   = 12'o0014;
  localparam logic [11:0] F_DSTAT  = 12'o0023;
  localparam logic [11:0] F_FD0    = 12'o0030;
  localparam logic [11:0] F_FD1    = 12'o0031;
  localparam logic [11:0] F_FD2    = 12'o0034;
  localparam logic [11:0] F_ESTAT  = 12'o0066;
  localparam logic [11:0] F_AUTO   = 12'o0067;
  localparam logic [11:0] F_AUTO2  = 12'o0414;

  localparam logic [3:0]  NO_UNIT   = 4'd15;
  localparam logic [11:0] ST_BAD    = 12'o5000;
  localparam logic [11:0] ST_NOUNIT = 12'o5020;
  localparam logic [14:0] FD_WORDS  = 15'd322;

  // Architectural state. Detail status keeps only the words that change;
  // the fixed ones are rebuilt at read time.
  typedef struct packed {
    logic [3:0]            sel;
    logic [11:0]           cf;
    logic [14:0]           wl;
    logic [11:0]           gsw;
    logic [NU-1:0][11:0]   cyl;
    logic [NU-1:0][11:0]   trk;
    logic [NU-1:0][11:0]   sec;
    logic [NU-1:0][11:0]   d2;
    logic [NU-1:0][11:0]   d4;
    logic [NU-1:0][11:0]   d5;
    logic [NU-1:0][11:0]   d6;
    logic [NU-1:0]         d9b;
    logic [NU-1:0]         d12b;
    logic [NU-1:0][11:0]   ext0;
    logic [NU-1:0][11:0]   ma0;
    logic [NU-1:0][11:0]   ma1;
    logic [NU-1:0][11:0]   wp2;
    logic [NU-1:0][11:0]   wp3;
  } state_t;

  typedef struct packed {
    logic [1:0]  func_reply;
    logic        word_valid;
    logic [11:0] word_out;
    logic        disconnect_after;
    logic        transfer_valid;
    logic        transfer_write;
    logic [18:0] sector_index;
    logic [23:0] mem_address;
    logic        transfer_ok;
    logic [11:0] control_flags;
    logic [11:0] control_link;
    logic [11:0] device_status;
  } result_t;

endpackage

FILE: hdl/dccs_core.sv
// Next-state and result logic for one channel word of the disk sequencer.
// Depends on dccs_pkg for the state and result types and the codes.
`timescale 1ns / 1ps
module dccs_core #(
  parameter int UNITS          = dccs_pkg::UNITS_DEF,
  parameter int CYLINDERS      = dccs_pkg::CYLINDERS_DEF,
  parameter int TRACKS         = dccs_pkg::TRACKS_DEF,
  parameter int SECTORS        = dccs_pkg::SECTORS_DEF,
  parameter int SECTOR_WORDS   = dccs_pkg::SECTOR_WORDS_DEF,
  parameter int AUTOLOAD_WORDS = dccs_pkg::AUTOLOAD_WORDS_DEF
) (
  input  dccs_pkg::state_t  st,
  input  logic [1:0]        mode,
  input  logic [11:0]       word,
  input  logic [7:0]        mask,
  input  logic [24:0]       ext_words,
  output dccs_pkg::state_t  nx,
  output dccs_pkg::result_t res,
  output logic              has_res
);
  import dccs_pkg::*;

  localparam logic [11:0] CYL_L  = 12'(CYLINDERS);
  localparam logic [11:0] TRK_L  = 12'(TRACKS);
  localparam logic [11:0] SEC_L  = 12'(SECTORS);
  localparam logic [16:0] TS_L   = 17'(TRACKS * SECTORS);
  localparam logic [7:0]  SPT_L  = 8'(SECTORS);
  localparam logic [25:0] SW_L   = 26'(SECTOR_WORDS);
  localparam logic [3:0]  UNITS_L = 4'(UNITS);
  localparam logic [14:0] AUTO_L = 15'(AUTOLOAD_WORDS);

  logic [2:0]  u, nu;
  logic        have, wr, ok, bad;
  logic [14:0] n;
  logic [11:0] c, t, s, s1, t1, ma0v, ma1v, v;
  logic [23:0] addr;
  logic [28:0] prod_c;
  logic [19:0] prod_t;
  logic [29:0] idx_sum;
  logic [4:0]  depth, ridx;
  logic        status_fn;

  always_comb begin
    nx      = st;
    res     = '0;
    has_res = 1'b0;
    u       = st.sel[2:0];
    have    = (st.sel != NO_UNIT);
    n       = st.wl;
    c       = st.cyl[u];
    t       = st.trk[u];
    s       = st.sec[u];
    nu      = word[2:0];
    wr      = (st.cf == F_WRITE);
    ma0v    = st.ma0[u];
    ma1v    = st.ma1[u];
    addr    = '0;
    ok      = 1'b0;
    bad     = 1'b0;
    s1      = '0;
    t1      = '0;
    prod_c  = '0;
    prod_t  = '0;
    idx_sum = '0;
    depth   = '0;
    ridx    = '0;
    v       = '0;
    status_fn = 1'b0;

    unique case (mode)
      MODE_FUNC: begin
        has_res = 1'b1;
        if (!have && word != F_SEEK && word != F_OPCOMP && word != F_GSTAT &&
            word != F_ESTAT && word != F_AUTO && word != F_AUTO2) begin
          res.func_reply = REPLY_DECL;
        end else begin
          res.func_reply = REPLY_ACPT;
          case (word)
            F_SEEK:  nx.wl = 15'd4;
            F_READ:  nx.wl = 15'd2;
            F_WRITE: nx.wl = 15'd6;
            F_OPCOMP: res.func_reply = REPLY_PROC;
            F_GSTAT: nx.wl = 15'd1;
            F_ESTAT: begin
              if (have) nx.ext0[u] = st.gsw;
              nx.wl = 15'd5;
            end
            F_DSTAT: begin
              nx.d2[u]  = 12'o0460;
              nx.d4[u]  = {6'd0, c[9:4]};
              nx.d5[u]  = {c[3:0], 8'd0} | t;
              nx.d6[u]  = {s[7:0], 4'b1000};
              nx.d9b[u] = t[0];
              nx.wl     = 15'd20;
            end
            F_CONT: ;
            F_AUTO, F_AUTO2: nx.wl = AUTO_L;
            F_FD0, F_FD1, F_FD2: nx.wl = FD_WORDS;
            default: res.func_reply = REPLY_DECL;
          endcase
          if (res.func_reply == REPLY_ACPT) nx.cf = word;
        end
      end

      MODE_OUT: begin
        if (st.cf == F_SEEK) begin
          nx.wl = n - 15'd1;
          if (n == 15'd4) begin
            if ({1'b0, nu} != st.sel) begin
              if ({1'b0, nu} < UNITS_L && mask[nu]) begin
                nx.sel      = {1'b0, nu};
                nx.d12b[nu] = 1'b0;
              end else begin
                nx.sel = NO_UNIT;
              end
            end else begin
              nx.d12b[u] = 1'b1;
            end
          end else if (n >= 15'd1 && n <= 15'd3) begin
            if (have) begin
              if (n == 15'd3) nx.cyl[u] = word;
              else if (n == 15'd2) nx.trk[u] = word;
              else begin
                nx.sec[u] = word;
                // Seek check on the just completed address.
                bad = (c >= CYL_L) || (t >= TRK_L) || (word >= SEC_L);
                nx.gsw   = bad ? ST_BAD : 12'd0;
                nx.d2[u] = bad ? 12'o0030 : 12'o0020;
                if (!bad) begin
                  nx.d4[u] = {4'd0, c[11:4]};
                  nx.d5[u] = {c[3:0], 8'd0} | t;
                  nx.d6[u] = {word[7:0], 4'b1000};
                end
              end
            end else if (n == 15'd1) begin
              nx.gsw = ST_NOUNIT;
            end
          end else begin
            nx.wl = '0;
          end
        end else if ((st.cf == F_READ || st.cf == F_WRITE) && have) begin
          nx.wl = n - 15'd1;
          if (n == 15'd0 || n > (wr ? 15'd6 : 15'd2)) begin
            nx.wl = '0;
          end else begin
            if (n == 15'd2 && !wr) nx.ma0[u] = word;
            else if (n == 15'd6) nx.ma0[u] = word;
            else if (n == 15'd5) nx.ma1[u] = word;
            else if (wr && n == 15'd2) nx.wp2[u] = word;
            else if (wr && n == 15'd1) nx.wp3[u] = word;
            else if (!wr) nx.ma1[u] = word;

            if (n == 15'd1) begin
              // Final parameter word: issue one sector transfer.
              has_res = 1'b1;
              if (!wr) ma1v = word;
              addr    = {ma0v, ma1v};
              ok      = ({2'b00, addr} + SW_L) <= {1'b0, ext_words};
              prod_c  = 29'(c * TS_L);
              prod_t  = 20'(t * SPT_L);
              idx_sum = {1'b0, prod_c} + {10'd0, prod_t} + {18'd0, s};
              res.transfer_valid = 1'b1;
              res.transfer_write = wr;
              res.sector_index   = idx_sum[18:0];
              res.mem_address    = addr;
              res.transfer_ok    = ok;
              if (wr) begin
                res.control_flags = st.wp2[u];
                res.control_link  = word;
              end
              if (!ok) begin
                nx.gsw   = ST_BAD;
                nx.d2[u] = wr ? 12'o0130 : 12'o0110;
              end else begin
                // Step the sector, wrapping into the next track.
                s1 = s + 12'd1;
                t1 = t;
                if (s1 >= SEC_L) begin
                  s1 = '0;
                  t1 = t + 12'd1;
                  if (t1 >= TRK_L) t1 = '0;
                end
                nx.sec[u] = s1;
                nx.trk[u] = t1;
                bad = (c >= CYL_L) || (t1 >= TRK_L) || (s1 >= SEC_L);
                nx.gsw   = bad ? ST_BAD : 12'd0;
                nx.d2[u] = bad ? 12'o0030 : 12'o0020;
                if (!bad) begin
                  nx.d4[u] = {4'd0, c[11:4]};
                  nx.d5[u] = {c[3:0], 8'd0} | t1;
                  nx.d6[u] = {s1[7:0], 4'b1000};
                end
              end
            end
          end
        end
      end

      MODE_IN: begin
        status_fn = 1'b1;
        case (st.cf)
          F_GSTAT: depth = 5'd1;
          F_ESTAT: depth = 5'd5;
          F_DSTAT: depth = 5'd20;
          default: status_fn = 1'b0;
        endcase
        if (status_fn) begin
          has_res        = 1'b1;
          res.word_valid = 1'b1;
          if (n == 15'd0 || n > {10'd0, depth}) begin
            nx.wl = '0;
            res.disconnect_after = 1'b1;
          end else begin
            ridx = depth - n[4:0];
            if (st.cf == F_GSTAT) begin
              v = st.gsw;
            end else if (have && st.cf == F_ESTAT) begin
              v = (ridx == 5'd0) ? st.ext0[u] : 12'd0;
            end else if (have) begin
              case (ridx)
                5'd1:  v = 12'o0371;
                5'd2:  v = st.d2[u];
                5'd3:  v = {9'o770, u};
                5'd4:  v = st.d4[u];
                5'd5:  v = st.d5[u];
                5'd6:  v = st.d6[u];
                5'd7:  v = {3'd0, u, 6'o37};
                5'd8:  v = 12'o1640;
                5'd9:  v = {10'b1110100000, st.d9b[u], 1'b1};
                5'd12: v = {2'd0, st.d12b[u], 9'd0};
                5'd17: v = 12'o0400;
                default: v = 12'd0;
              endcase
            end
            res.word_out = v;
            nx.wl = n - 15'd1;
            res.disconnect_after = (n == 15'd1);
          end
        end
      end

      MODE_DISC: ;
      default: ;
    endcase

    if (has_res) res.device_status = nx.gsw;
  end

endmodule

FILE: hdl/disk_controller_channel_sequencer.sv
// A word waits in the input register; dccs_core places its result in the
// output register as it retires. Throughput: one word per cycle while the
// output is not stalled, set by the single pass of dccs_core between them.
// Words that cause no result retire without touching the output register.
// Reset (synchronous, rst_n low) empties both registers, deselects the unit
// and restores all per-unit status to its power-on values at once.
`timescale 1ns / 1ps
`include "disk_controller_channel_sequencer_assert.svh"
module disk_controller_channel_sequencer #(
  parameter int UNITS          = dccs_pkg::UNITS_DEF,
  parameter int CYLINDERS      = dccs_pkg::CYLINDERS_DEF,
  parameter int TRACKS         = dccs_pkg::TRACKS_DEF,
  parameter int SECTORS        = dccs_pkg::SECTORS_DEF,
  parameter int SECTOR_WORDS   = dccs_pkg::SECTOR_WORDS_DEF,
  parameter int AUTOLOAD_WORDS = dccs_pkg::AUTOLOAD_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // word[11:0], zero fill
  input  logic [1:0]   in_tuser,   // mode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // func_reply[1:0], word_valid[2], word_out[14:3], transfer_valid[15],
  // transfer_write[16], sector_index[35:17], mem_address[59:36],
  // transfer_ok[60], control_flags[72:61], control_link[84:73],
  // device_status[96:85], zero fill to 103
  output logic [103:0] out_tdata,
  output logic         out_tlast,  // disconnect_after
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [24:0]  cfg_wdata
);
  import dccs_pkg::*;

  localparam logic CFG_MASK = 1'b0;
  localparam logic CFG_EXT  = 1'b1;

  logic        in_v_r;
  logic [1:0]  mode_r;
  logic [11:0] word_r;
  logic        out_v_r;
  result_t     res_r;
  state_t      st_r, st_nxt;
  state_t      st_init;
  result_t     res_nxt;
  logic        has_res;
  logic        adv;
  logic [7:0]  mask_r;
  logic [24:0] ext_r;

  dccs_core #(
    .UNITS(UNITS), .CYLINDERS(CYLINDERS), .TRACKS(TRACKS), .SECTORS(SECTORS),
    .SECTOR_WORDS(SECTOR_WORDS), .AUTOLOAD_WORDS(AUTOLOAD_WORDS)
  ) u_core (
    .st(st_r), .mode(mode_r), .word(word_r), .mask(mask_r), .ext_words(ext_r),
    .nx(st_nxt), .res(res_nxt), .has_res(has_res)
  );

  // A held word retires when it needs no output slot or the slot frees up.
  assign adv       = in_v_r && (!has_res || !out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      mode_r <= in_tuser;
      word_r <= in_tdata[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && has_res) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (adv && has_res) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'd1;
      ext_r  <= 25'd1048576;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK: mask_r <= cfg_wdata[7:0];
        CFG_EXT:  ext_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Power-on pattern: no unit selected, detail words 2 and 6 at their
  // idle values, everything else zero.
  always_comb begin
    st_init     = '0;
    st_init.sel = NO_UNIT;
    for (int i = 0; i < NU; i++) begin
      st_init.d2[i] = 12'o0020;
      st_init.d6[i] = 12'o0010;
    end
  end

  // Per-unit status returns to its power-on pattern on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_init;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = res_r.disconnect_after;
  assign out_tdata  = {7'd0, res_r.device_status, res_r.control_link,
                       res_r.control_flags, res_r.transfer_ok, res_r.mem_address,
                       res_r.sector_index, res_r.transfer_write,
                       res_r.transfer_valid, res_r.word_out, res_r.word_valid,
                       res_r.func_reply};

  `DCCS_ASSERT_NOW(a_word_zero, out_v_r && !res_r.word_valid, res_r.word_out == 12'd0 && !res_r.disconnect_after, "status word without word_valid")
  `DCCS_ASSERT_NOW(a_xfer_zero, out_v_r && !res_r.transfer_valid, res_r.mem_address == 24'd0 && res_r.sector_index == 19'd0 && !res_r.transfer_ok, "transfer fields without transfer_valid")
  `DCCS_ASSERT_NOW(a_sel_range, 1'b1, st_r.sel == NO_UNIT || st_r.sel < 4'(UNITS), "selected unit out of range")
  `DCCS_ASSERT_NEXT(a_in_hold, in_v_r && !adv, in_v_r && $stable(word_r) && $stable(mode_r), "held word lost")

endmodule

FILE: bench/disk_controller_channel_sequencer_tb.sv
// Self-checking bench for disk_controller_channel_sequencer: directed and random channel words,
// a scoreboard class that predicts every reply, and random stalls on both stream sides.
// Depends on dccs_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module disk_controller_channel_sequencer_tb;
  import dccs_pkg::*;

  // The scoreboard keeps its own copy of the sequencer state. Each accepted
  // channel word is run through the prediction below, and any reply it
  // causes waits in a queue until the block emits the matching output word.
  class sequencer_scoreboard;
    logic [7:0]  present_mask;
    logic [24:0] ext_mem_size;
    int          sel;
    logic [11:0] cur_func;
    logic [14:0] left;
    logic [11:0] gstat;
    logic [11:0] cyl[8], trk[8], sec[8];
    logic [11:0] detail[8][20];
    logic [11:0] ext_stat[8][5];
    logic [11:0] mem_addr[8][2];
    logic [11:0] wr_param[8][4];
    result_t     expected_replies[$];
    int          errors, checked, transfers;

    function new();
      present_mask = 8'd1;
      ext_mem_size = 25'd1048576;
      sel = int'(NO_UNIT);
      cur_func = '0;
      left = '0;
      gstat = '0;
      errors = 0;
      checked = 0;
      transfers = 0;
      for (int u = 0; u < 8; u++) begin
        cyl[u] = '0; trk[u] = '0; sec[u] = '0;
        for (int i = 0; i < 20; i++) detail[u][i] = '0;
        for (int i = 0; i < 5; i++) ext_stat[u][i] = '0;
        for (int i = 0; i < 2; i++) mem_addr[u][i] = '0;
        for (int i = 0; i < 4; i++) wr_param[u][i] = '0;
        // Power-on detail status words of each drive.
        detail[u][1]  = 12'o0371;
        detail[u][2]  = 12'o0020;
        detail[u][3]  = 12'o7700 | 12'(u);
        detail[u][6]  = 12'o0010;
        detail[u][7]  = 12'(u << 6) | 12'o0037;
        detail[u][8]  = 12'o1640;
        detail[u][9]  = 12'o7201;
        detail[u][17] = 12'o0400;
      end
    endfunction

    function void set_register(bit idx, logic [24:0] value);
      if (idx == 1'b0) present_mask = value[7:0];
      else ext_mem_size = value;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function bit unit_ok();
      return sel < 8;
    endfunction

    // Validate the position of unit u and refresh its position status words.
    function void check_position(int u);
      gstat = '0;
      detail[u][2] = 12'o0020;
      if (cyl[u] >= 843 || trk[u] >= 10 || sec[u] >= 32) begin
        gstat = ST_BAD;
        detail[u][2] |= 12'o0010;
        return;
      end
      detail[u][4] = {4'b0, cyl[u][11:4]};
      detail[u][5] = {cyl[u][3:0], trk[u][7:0]};
      detail[u][6] = {sec[u][7:0], 4'b1000};
    endfunction

    // Issue one sector transfer for unit u and step to the next sector.
    function void issue_transfer(int u, bit wr, ref result_t r);
      logic [23:0] addr;
      int unsigned lin;
      bit ok;
      addr = {mem_addr[u][0], mem_addr[u][1]};
      ok = (32'(addr) + 32'd256) <= 32'(ext_mem_size);
      lin = int'(cyl[u]) * 320 + int'(trk[u]) * 32 + int'(sec[u]);
      gstat = '0;
      detail[u][2] = wr ? 12'o0120 : 12'o0100;
      r.transfer_valid = 1'b1;
      r.transfer_write = wr;
      r.sector_index = lin[18:0];
      r.mem_address = addr;
      r.transfer_ok = ok;
      if (wr) begin
        r.control_flags = wr_param[u][2];
        r.control_link = wr_param[u][3];
      end
      if (!ok) begin
        gstat = ST_BAD;
        detail[u][2] |= 12'o0010;
        return;
      end
      sec[u] = sec[u] + 12'd1;
      if (sec[u] >= 32) begin
        sec[u] = '0;
        trk[u] = trk[u] + 12'd1;
        if (trk[u] >= 10) trk[u] = '0;
      end
      check_position(u);
    endfunction

    function logic [1:0] take_function(logic [11:0] f);
      if (!unit_ok() && f != F_SEEK && f != F_OPCOMP && f != F_GSTAT && f != F_ESTAT &&
          f != F_AUTO && f != F_AUTO2)
        return REPLY_DECL;
      case (f)
        F_SEEK:   left = 15'd4;
        F_READ:   left = 15'd2;
        F_WRITE:  left = 15'd6;
        F_OPCOMP: return REPLY_PROC;
        F_GSTAT:  left = 15'd1;
        F_ESTAT: begin
          if (unit_ok()) ext_stat[sel][0] = gstat;
          left = 15'd5;
        end
        F_DSTAT: begin
          detail[sel][2] = 12'o0460;
          detail[sel][4] = {6'b0, cyl[sel][9:4]};
          // The whole track word is merged below the low cylinder bits.
          detail[sel][5] = {cyl[sel][3:0], 8'b0} | trk[sel];
          detail[sel][6] = {sec[sel][7:0], 4'b1000};
          detail[sel][9][1] = trk[sel][0];
          left = 15'd20;
        end
        F_CONT: ;
        F_AUTO, F_AUTO2: left = 15'd16870;
        F_FD0, F_FD1, F_FD2: left = FD_WORDS;
        default: return REPLY_DECL;
      endcase
      cur_func = f;
      return REPLY_ACPT;
    endfunction

    // Parameter word from the channel; returns 1 when it completes a transfer.
    function bit take_param(logic [11:0] w, ref result_t r);
      int n, nu;
      bit wr;
      n = int'(left);
      if (cur_func == F_SEEK) begin
        left = left - 15'd1;
        if (n == 4) begin
          nu = int'(w[2:0]);
          if (nu != sel) begin
            if (present_mask[nu]) begin
              sel = nu;
              detail[nu][12][9] = 1'b0;
            end else begin
              sel = int'(NO_UNIT);
            end
          end else begin
            detail[sel][12][9] = 1'b1;
          end
        end else if (n >= 1 && n <= 3) begin
          if (unit_ok()) begin
            if (n == 3) cyl[sel] = w;
            else if (n == 2) trk[sel] = w;
            else begin
              sec[sel] = w;
              check_position(sel);
            end
          end else if (n == 1) begin
            gstat = ST_NOUNIT;
          end
        end else begin
          left = '0;
        end
        return 1'b0;
      end
      if ((cur_func == F_READ || cur_func == F_WRITE) && unit_ok()) begin
        wr = (cur_func == F_WRITE);
        left = left - 15'd1;
        if (n == 0 || n > (wr ? 6 : 2)) begin
          left = '0;
          return 1'b0;
        end
        if (n == 2 && !wr) mem_addr[sel][0] = w;
        else if (n >= 5) mem_addr[sel][6 - n] = w;
        else if (wr) wr_param[sel][4 - n] = w;
        else mem_addr[sel][1] = w;
        if (n == 1) begin
          issue_transfer(sel, wr, r);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Input request from the channel; returns 1 when a status word is sent.
    function bit take_request(ref result_t r);
      int depth, idx;
      logic [11:0] v;
      v = '0;
      if (cur_func == F_GSTAT) depth = 1;
      else if (cur_func == F_ESTAT) depth = 5;
      else if (cur_func == F_DSTAT) depth = 20;
      else return 1'b0;
      r.word_valid = 1'b1;
      if (left == 0 || left > depth) begin
        left = '0;
        r.disconnect_after = 1'b1;
        return 1'b1;
      end
      idx = depth - left;
      if (cur_func == F_GSTAT) v = gstat;
      else if (unit_ok())
        v = (cur_func == F_ESTAT) ? ext_stat[sel][idx] : detail[sel][idx];
      r.word_out = v;
      left = left - 15'd1;
      if (left == 0) r.disconnect_after = 1'b1;
      return 1'b1;
    endfunction

    function void accept_word(logic [1:0] mode, logic [11:0] w);
      result_t r;
      bit has_reply;
      r = '0;
      has_reply = 1'b0;
      case (mode)
        MODE_FUNC: begin
          r.func_reply = take_function(w);
          has_reply = 1'b1;
        end
        MODE_OUT: has_reply = take_param(w, r);
        MODE_IN:  has_reply = take_request(r);
        default: ;
      endcase
      if (has_reply) begin
        r.device_status = gstat;
        expected_replies.push_back(r);
      end
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_reply(logic [103:0] d, logic last);
      result_t e;
      if (expected_replies.size() == 0) begin
        $error("unexpected output word %h", d);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      checked++;
      if (e.transfer_valid) transfers++;
      compare("func_reply", 32'(e.func_reply), 32'(d[1:0]));
      compare("word_valid", 32'(e.word_valid), 32'(d[2]));
      compare("word_out", 32'(e.word_out), 32'(d[14:3]));
      compare("disconnect_after", 32'(e.disconnect_after), 32'(last));
      compare("transfer_valid", 32'(e.transfer_valid), 32'(d[15]));
      compare("transfer_write", 32'(e.transfer_write), 32'(d[16]));
      compare("sector_index", 32'(e.sector_index), 32'(d[35:17]));
      compare("mem_address", 32'(e.mem_address), 32'(d[59:36]));
      compare("transfer_ok", 32'(e.transfer_ok), 32'(d[60]));
      compare("control_flags", 32'(e.control_flags), 32'(d[72:61]));
      compare("control_link", 32'(e.control_link), 32'(d[84:73]));
      compare("device_status", 32'(e.device_status), 32'(d[96:85]));
      compare("zero fill", 32'd0, {25'd0, d[103:97]});
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         cfg_we;
  logic         cfg_index;
  logic [24:0]  cfg_wdata;

  sequencer_scoreboard board;
  int words_sent;
  bit no_idle;  // set for the closing stretch, where neither side pauses

  disk_controller_channel_sequencer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: the receiver stalls in short random bursts until the
  // closing stretch of the run.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Every accepted output word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_reply(out_tdata, out_tlast);
  end

  // Present one word, hold it until accepted, then maybe pause for a burst.
  task automatic send_word(logic [1:0] mode, logic [11:0] w);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {4'b0, w};
    in_tuser = mode;
    do @(posedge clk); while (!in_tready);
    board.accept_word(mode, w);
    words_sent++;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Wait until every predicted reply has come out and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(bit idx, logic [24:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    board.set_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [11:0] pick(int lo, int hi);
    // Mostly a value inside the legal range, sometimes any 12-bit word.
    if ($urandom_range(0, 9) == 0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(lo, hi));
  endfunction

  // One random channel sequence: mostly complete seeks, transfers and status
  // reads with random content, plus truncated sequences and plain noise.
  task automatic random_sequence();
    logic [11:0] f;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_word(MODE_FUNC, F_SEEK);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 4;
        if (n > 0) send_word(MODE_OUT, ($urandom_range(0, 3) == 0) ?
                             12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 7)));
        if (n > 1) send_word(MODE_OUT, pick(0, 842));
        if (n > 2) send_word(MODE_OUT, pick(0, 9));
        if (n > 3) send_word(MODE_OUT, pick(0, 31));
        repeat (n > 4 ? n - 4 : 0) send_word(MODE_OUT, 12'($urandom_range(0, 4095)));
      end
      3, 4: begin
        send_word(MODE_FUNC, F_READ);
        send_word(MODE_OUT, pick(0, 260));
        send_word(MODE_OUT, 12'($urandom_range(0, 4095)));
        if ($urandom_range(0, 9) == 0) send_word(MODE_OUT, 12'($urandom_range(0, 4095)));
      end
      5: begin
        send_word(MODE_FUNC, F_WRITE);
        send_word(MODE_OUT, pick(0, 260));
        repeat (5) send_word(MODE_OUT, 12'($urandom_range(0, 4095)));
      end
      6: begin
        case ($urandom_range(0, 2))
          0: begin f = F_GSTAT; n = 2; end
          1: begin f = F_ESTAT; n = 6; end
          default: begin f = F_DSTAT; n = 21; end
        endcase
        send_word(MODE_FUNC, f);
        repeat ($urandom_range(0, n)) send_word(MODE_IN, 12'($urandom_range(0, 4095)));
      end
      7: begin
        repeat ($urandom_range(1, 4))
          send_word(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
      end
      8: begin
        case ($urandom_range(0, 6))
          0: f = F_OPCOMP;
          1: f = F_CONT;
          2: f = F_FD0;
          3: f = F_FD1;
          4: f = F_FD2;
          5: f = F_AUTO;
          default: f = F_AUTO2;
        endcase
        send_word(MODE_FUNC, f);
        repeat ($urandom_range(0, 3))
          send_word($urandom_range(0, 1) ? MODE_OUT : MODE_IN, 12'($urandom_range(0, 4095)));
      end
      default: begin
        send_word(MODE_DISC, 12'($urandom_range(0, 4095)));
        send_word(MODE_FUNC, 12'($urandom_range(0, 4095)));
      end
    endcase
  endtask

  initial begin
    board = new();
    words_sent = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_FUNC;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening with the power-on settings: only unit 0 exists.
    send_word(MODE_FUNC, F_READ);       // declined, nothing selected yet
    send_word(MODE_OUT, 12'o7777);      // parameter word with no unit is ignored
    send_word(MODE_FUNC, F_SEEK);       // seek with no unit present
    send_word(MODE_OUT, 12'o0007);
    send_word(MODE_OUT, 12'd0);
    send_word(MODE_OUT, 12'd0);
    send_word(MODE_OUT, 12'd0);
    send_word(MODE_FUNC, F_GSTAT);
    send_word(MODE_IN, 12'd0);
    send_word(MODE_IN, 12'd0);          // status past its end
    send_word(MODE_FUNC, F_SEEK);       // last sector of the last track
    send_word(MODE_OUT, 12'd0);
    send_word(MODE_OUT, 12'd842);
    send_word(MODE_OUT, 12'd9);
    send_word(MODE_OUT, 12'd31);
    send_word(MODE_FUNC, F_WRITE);      // transfer wraps sector and track
    send_word(MODE_OUT, 12'd0);
    send_word(MODE_OUT, 12'd0);
    send_word(MODE_OUT, 12'o7777);
    send_word(MODE_OUT, 12'o7777);
    send_word(MODE_OUT, 12'o7777);
    send_word(MODE_OUT, 12'd0);
    send_word(MODE_OUT, 12'd5);         // extra parameter word
    send_word(MODE_FUNC, F_DSTAT);
    repeat (3) send_word(MODE_IN, 12'd0);
    send_word(MODE_FUNC, F_FD0);        // input requests after factory data give no reply
    send_word(MODE_IN, 12'd0);
    send_word(MODE_FUNC, 12'o7777);     // unknown code
    send_word(MODE_DISC, 12'o7777);

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            write_register(1'b0, 25'hFF);
            write_register(1'b1, 25'd16777216);
          end
          2: begin
            write_register(1'b0, 25'h00);
            write_register(1'b1, 25'd0);
          end
          3: begin
            write_register(1'b0, 25'($urandom_range(1, 255)));
            write_register(1'b1, 25'd300000);
          end
          default: begin
            write_register(1'b0, 25'hFF);
            write_register(1'b1, 25'($urandom_range(0, 33554431)));
          end
        endcase
      end
      while (words_sent < 400 * (phase + 1)) begin
        if (words_sent > 1800) no_idle = 1'b1;
        random_sequence();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d channel words over five register settings;", words_sent);
    $display("checked %0d replies, %0d of them sector transfers.", board.checked,
             board.transfers);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
